@@ design/assert_macros.svh @@
// Assertion macros used by the transform chain unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/rtc_pkg.sv @@
package rtc_pkg;
	localparam int NumStations = 8;
	localparam int NumModules = 16;
	localparam int MaxTransforms = 4;
	localparam int CoefsPerXf = 12;
	localparam int ModW = $clog2(NumStations * NumModules);
	localparam int SlotW = $clog2(MaxTransforms);
	localparam int CntW = $clog2(MaxTransforms + 1);
	localparam int XfAddrW = ModW + SlotW;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_COUNT = 2'd1,
		ACT_FWD = 2'd2,
		ACT_INV = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_WRITE = 2'd0,
		ST_POINT = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_SUB = 7'b0000100,
		S_MUL = 7'b0001000,
		S_ACC = 7'b0010000,
		S_NEXT = 7'b0100000,
		S_OUT = 7'b1000000
	} fsm_t;
endpackage

@@ design/rigid_transform_chain_unit.sv @@
// Channel | Direction | Handshake             | Fields
// request | in        | valid / stall         | action station module_req slot coeff_index
//         |           |                       | coeff_value transform_count x_in y_in z_in
// result  | out       | out_valid / out_stall | x_out y_out z_out status
// A write or count request passes S_SUB and S_OUT before the next request is taken.
// A point loops once per used transform (up to four): each transform reads one
// coefficient row, forms the input vector, runs nine multiply-accumulate steps
// on one shared 32x33 multiplier and then checks the step count.
// Reset clears the handshake control and the valid bits of the module counts; neither memory
// is cleared. A result waits in the output register, so out_stall holds back only the next one.
`include "assert_macros.svh"
module rigid_transform_chain_unit import rtc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [1:0] action,
	input logic [2:0] station,
	input logic [3:0] module_req,
	input logic [1:0] slot,
	input logic [3:0] coeff_index,
	input logic signed [31:0] coeff_value,
	input logic [2:0] transform_count,
	input logic signed [31:0] x_in,
	input logic signed [31:0] y_in,
	input logic signed [31:0] z_in,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic signed [31:0] z_out,
	output logic [1:0] status
);
	logic [CoefsPerXf*32-1:0] xf_mem [NumStations*NumModules*MaxTransforms];
	logic [CntW-1:0] cnt_mem [NumStations*NumModules];
	logic [NumStations*NumModules-1:0] cnt_vld_q;
	logic [CntW-1:0] cnt_rd_q;
	logic cnt_seen_q;
	logic [CntW-1:0] n_cnt;
	logic [CoefsPerXf*32-1:0] row_q;
	logic [CoefsPerXf*32-1:0] merged;
	fsm_t state_q;
	logic [1:0] act_q;
	logic [ModW-1:0] mod_q;
	logic [SlotW-1:0] slot_q;
	logic [3:0] ci_q;
	logic signed [31:0] cv_q;
	logic in_range_q;
	logic [CntW-1:0] step_q;
	logic [3:0] k_q;
	logic signed [32:0] v_q [3];
	logic signed [31:0] np_q [3];
	logic signed [31:0] tmp_q [3];
	logic signed [64:0] prod_s1;
	logic signed [63:0] hi_q;
	logic [31:0] lo_q;
	logic flag_q;
	logic accept;
	logic wr_en;
	logic cnt_we;
	logic [CntW-1:0] cnt_wdata;
	logic [XfAddrW-1:0] rd_addr;
	logic [SlotW-1:0] xf;
	logic [1:0] row_i;
	logic [1:0] col_j;
	logic signed [31:0] coef;
	logic in_rng;
	logic [ModW-1:0] mod_idx;
	logic acc_done;
	logic [31:0] lo_fin;
	logic signed [63:0] dot_fin;
	logic signed [63:0] res_fin;
	logic signed [31:0] sat_fin;
	logic sat_fin_hit;

	assign in_rng = (32'(station) < NumStations) && (32'(module_req) < NumModules);
	assign mod_idx = in_rng ? ModW'(32'(station) * NumModules + 32'(module_req)) : '0;
	assign stall = (state_q != S_IDLE);
	assign accept = valid && !stall;
	assign n_cnt = cnt_seen_q ? cnt_rd_q : '0;
	assign xf = (act_q == ACT_FWD) ? SlotW'(step_q) : SlotW'(n_cnt - step_q - 1'b1);
	assign rd_addr = (state_q == S_IDLE) ? {mod_idx, slot} : {mod_q, xf};
	assign row_i = 2'(k_q >> 2);
	assign col_j = k_q[1:0];
	assign acc_done = (state_q == S_ACC) && (col_j == 2'd2);
	assign cnt_we = accept && (action == ACT_COUNT) && in_rng;
	assign cnt_wdata = (32'(transform_count) > MaxTransforms)
		? CntW'(MaxTransforms) : CntW'(transform_count);

	always_comb begin
		merged = row_q;
		if (32'(ci_q) < CoefsPerXf) begin
			merged[32*ci_q +: 32] = cv_q;
		end
		if (act_q == ACT_FWD) begin
			coef = row_q[32*(32'(row_i)*3 + 32'(col_j)) +: 32];
		end else begin
			coef = row_q[32*(32'(col_j)*3 + 32'(row_i)) +: 32];
		end
	end

	assign wr_en = (state_q == S_SUB) && (act_q == ACT_WRITE) && in_range_q
		&& (32'(ci_q) < CoefsPerXf);

	always_ff @(posedge clk) begin
		row_q <= xf_mem[rd_addr];
		if (wr_en) begin
			xf_mem[{mod_q, slot_q}] <= merged;
		end
		prod_s1 <= $signed(coef) * v_q[col_j];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[mod_idx] <= cnt_wdata;
		end
		if (accept) begin
			cnt_rd_q <= cnt_mem[mod_idx];
		end
	end

	assign lo_fin = lo_q + {2'b0, prod_s1[29:0]} + 32'h2000_0000;
	assign dot_fin = hi_q + 64'(prod_s1 >>> 30) + 64'({34'b0, lo_fin[31:30]});

	always_comb begin
		res_fin = (act_q == ACT_FWD)
			? dot_fin + 64'($signed(row_q[32*(9 + 32'(row_i)) +: 32])) : dot_fin;
		sat_fin_hit = 1'b1;
		if (res_fin > 64'sd2147483647) begin
			sat_fin = 32'sh7FFF_FFFF;
		end else if (res_fin < -64'sd2147483648) begin
			sat_fin = 32'sh8000_0000;
		end else begin
			sat_fin = res_fin[31:0];
			sat_fin_hit = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_done) begin
			tmp_q[row_i] <= sat_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			cnt_vld_q <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_OUT) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q <= action;
						mod_q <= mod_idx;
						slot_q <= slot;
						ci_q <= coeff_index;
						cv_q <= coeff_value;
						in_range_q <= in_rng;
						cnt_seen_q <= cnt_vld_q[mod_idx];
						step_q <= '0;
						flag_q <= 1'b0;
						v_q[0] <= 33'(x_in);
						v_q[1] <= 33'(y_in);
						v_q[2] <= 33'(z_in);
						np_q[0] <= x_in;
						np_q[1] <= y_in;
						np_q[2] <= z_in;
						if (cnt_we) begin
							cnt_vld_q[mod_idx] <= 1'b1;
						end
						state_q <= (action == ACT_FWD || action == ACT_INV) ? S_NEXT : S_SUB;
					end
				end
				S_NEXT: begin
					if (!in_range_q || step_q == n_cnt) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_SUB;
				S_SUB: begin
					if (act_q == ACT_WRITE || act_q == ACT_COUNT) begin
						state_q <= S_OUT;
					end else begin
						for (int i = 0; i < 3; i++) begin
							v_q[i] <= (act_q == ACT_INV)
								? 33'(np_q[i]) - 33'($signed(row_q[32*(9+i) +: 32]))
								: 33'(np_q[i]);
						end
						k_q <= '0;
						hi_q <= '0;
						lo_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (col_j == 2'd2) begin
						hi_q <= '0;
						lo_q <= '0;
						if (sat_fin_hit) flag_q <= 1'b1;
						if (row_i == 2'd2) begin
							np_q[0] <= tmp_q[0];
							np_q[1] <= tmp_q[1];
							np_q[2] <= sat_fin;
							step_q <= step_q + 1'b1;
							state_q <= S_NEXT;
						end else begin
							k_q <= {k_q[3:2] + 2'd1, 2'd0};
							state_q <= S_MUL;
						end
					end else begin
						hi_q <= hi_q + 64'(prod_s1 >>> 30);
						lo_q <= lo_q + {2'b0, prod_s1[29:0]};
						k_q <= k_q + 4'd1;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						if (act_q == ACT_FWD || act_q == ACT_INV) begin
							x_out <= np_q[0];
							y_out <= np_q[1];
							z_out <= np_q[2];
							status <= flag_q ? ST_SAT : ST_POINT;
						end else begin
							x_out <= '0;
							y_out <= '0;
							z_out <= '0;
							status <= ST_WRITE;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_out_after, clk, arst_n, state_q == S_OUT, out_valid)
	`ASSERT_IMPLIES(a_stall_busy, clk, arst_n, state_q != S_IDLE, stall)
	`ASSERT_IMPLIES(a_step_bound, clk, arst_n, state_q == S_READ, step_q < n_cnt)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(x_out) && $stable(status))
endmodule
